// ===== rtl/core/md5he_pkg.sv =====
// md5he_pkg: shared types, constants and round tables for the MD5 hash engine.
// No dependencies; used by md5he_round and md5_hash_engine.

package md5he_pkg;

  typedef logic [3:0][31:0] words_t;

  // Round datapath control from the sequencer.
  typedef struct packed {
    logic       load;  // copy chaining words into the working words
    logic       step;  // run one round
    logic [5:0] rnd;   // round number 0..63
  } rnd_ctl_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam words_t      IV_WORDS = {IV_D, IV_C, IV_B, IV_A};

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [5:0]  LEN_OFFSET = 6'd56;

  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [31:0] k_const(input logic [5:0] rnd);
    return K_TABLE[rnd];
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
    return ROT_TABLE[{rnd[5:4], rnd[1:0]}];
  endfunction

  // Message word used by round j.
  function automatic logic [3:0] msg_idx(input logic [5:0] j);
    logic [3:0] jl;
    logic [3:0] idx;
    jl = j[3:0];
    unique case (j[5:4])
      2'd0:    idx = jl;
      2'd1:    idx = 4'(jl * 4'd5 + 4'd1);
      2'd2:    idx = 4'(jl * 4'd3 + 4'd5);
      default: idx = 4'(jl * 4'd7);
    endcase
    return idx;
  endfunction

endpackage

// ===== rtl/core/md5he_round.sv =====
// md5he_round: MD5 working words and the one-round-per-cycle datapath.
// Depends on md5he_pkg (words_t, rnd_ctl_t, round tables).

module md5he_round (
  input  logic                clk_i,
  input  md5he_pkg::rnd_ctl_t ctl_i,
  input  md5he_pkg::words_t   chain_i,
  input  logic [31:0]         msg_i,
  output md5he_pkg::words_t   words_o
);

  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_wide;
  logic [31:0] new_b;

  always_comb begin
    unique case (ctl_i.rnd[5:4])
      2'd0:    f = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f = (b_q & d_q) | (c_q & ~d_q);
      2'd2:    f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
  end

  assign sum      = a_q + f + md5he_pkg::k_const(ctl_i.rnd) + msg_i;
  // rotate left: upper half of the doubled word shifted
  assign rot_wide = {sum, sum} << md5he_pkg::rot_amt(ctl_i.rnd);
  assign new_b    = b_q + rot_wide[63:32];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      a_q <= chain_i[0];
      b_q <= chain_i[1];
      c_q <= chain_i[2];
      d_q <= chain_i[3];
    end else if (ctl_i.step) begin
      a_q <= d_q;
      b_q <= new_b;
      c_q <= b_q;
      d_q <= c_q;
    end
  end

  assign words_o = {d_q, c_q, b_q, a_q};

endmodule

// ===== rtl/core/md5_hash_engine.sv =====
// md5_hash_engine: MD5 digest of a byte stream, one optional byte per input transfer.
// Depends on md5he_pkg and md5he_round.
//
// Input channel (in_valid_i/in_ready_o): each transfer carries data_byte_i when
// byte_present_i is set, and end_of_message_i closes the message after that byte.
// Output channel (out_valid_o/out_ready_i): four transfers per message, digest words
// 0..3 (least significant byte first within each word), last_word_o on word 3.
// Input bytes are accepted back to back while idle; every 64th byte starts the block
// transform (a load, 64 rounds through the single round unit fed from the
// block memory read port, and a chaining add). Finalizing takes up to 16 padding
// word writes plus a transform, twice when the length no longer fits, then the four
// digest words are emitted in order, each waiting while the receiver stalls.
// The input is held off while padding, transforming and emitting words 0..2.
// A stalled receiver holds the output register; the next word waits behind it,
// and after word 3 is loaded new input is taken while it is still pending.
// Reset loads the MD5 initial chaining values and clears the byte count; the
// block memory needs no initialization since every byte is written before use.

module md5_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [60:0] cnt_q, cnt_d;
  logic [3:0]  pw_q, pw_d;
  logic        first_q, first_d;
  logic        second_q, second_d;
  logic        pad_on_q, pad_on_d;
  logic        eom_q, eom_d;
  logic        len_done_q, len_done_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [1:0]  oi_q, oi_d;
  md5he_pkg::words_t chain_q, chain_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] dw_q, dw_d;
  logic [1:0]  wi_q, wi_d;
  logic        lw_q, lw_d;

  logic [31:0] blk_mem [16];
  logic [3:0]  mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [3:0]  mem_raddr;
  logic [31:0] mem_rdata_q;

  md5he_pkg::rnd_ctl_t rnd_ctl;
  md5he_pkg::words_t   round_words;

  logic        in_fire;
  logic        len_blk;
  logic [63:0] bit_len;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign bit_len    = {cnt_q, 3'b000};
  assign len_blk    = second_q | (cnt_q[5:0] < md5he_pkg::LEN_OFFSET);

  md5he_round u_round (
    .clk_i   (clk_i),
    .ctl_i   (rnd_ctl),
    .chain_i (chain_q),
    .msg_i   (mem_rdata_q),
    .words_o (round_words)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pw_d        = pw_q;
    first_d     = first_q;
    second_d    = second_q;
    pad_on_d    = pad_on_q;
    eom_d       = eom_q;
    len_done_d  = len_done_q;
    rnd_d       = rnd_q;
    oi_d        = oi_q;
    chain_d     = chain_q;
    out_valid_d = out_valid_q;
    dw_d        = dw_q;
    wi_d        = wi_q;
    lw_d        = lw_q;
    mem_we      = 4'b0000;
    mem_waddr   = pw_q;
    mem_wdata   = '0;
    mem_raddr   = 4'd0;
    rnd_ctl     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (byte_present_i) begin
            mem_we    = 4'(4'b0001 << cnt_q[1:0]);
            mem_waddr = cnt_q[5:2];
            mem_wdata = {4{data_byte_i}};
            cnt_d     = cnt_q + 61'd1;
          end
          eom_d      = end_of_message_i;
          pad_on_d   = 1'b0;
          len_done_d = 1'b0;
          if (byte_present_i && (cnt_q[5:0] == 6'd63)) begin
            state_d = ST_LOAD;
          end else if (end_of_message_i) begin
            state_d  = ST_PAD;
            pw_d     = cnt_d[5:2];
            first_d  = 1'b1;
            second_d = 1'b0;
            pad_on_d = 1'b1;
          end
        end
      end
      ST_PAD: begin
        mem_waddr = pw_q;
        if (first_q) begin
          // partial word: keep message bytes below the pad marker
          mem_we    = 4'(4'b1111 << cnt_q[1:0]);
          mem_wdata = 32'({24'd0, md5he_pkg::PAD_BYTE}) << {cnt_q[1:0], 3'b000};
        end else begin
          mem_we = 4'b1111;
          if (len_blk && (pw_q == 4'd14)) begin
            mem_wdata = bit_len[31:0];
          end else if (len_blk && (pw_q == 4'd15)) begin
            mem_wdata = bit_len[63:32];
          end
        end
        first_d = 1'b0;
        if (pw_q == 4'd15) begin
          state_d    = ST_LOAD;
          len_done_d = len_blk;
        end else begin
          pw_d = pw_q + 4'd1;
        end
      end
      ST_LOAD: begin
        mem_raddr    = md5he_pkg::msg_idx(6'd0);
        rnd_ctl.load = 1'b1;
        rnd_d        = 6'd0;
        state_d      = ST_RND;
      end
      ST_RND: begin
        // prefetch the next round's message word
        mem_raddr    = md5he_pkg::msg_idx(6'(rnd_q + 6'd1));
        rnd_ctl.step = 1'b1;
        rnd_ctl.rnd  = rnd_q;
        rnd_d        = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 4; i++) begin
          chain_d[i] = chain_q[i] + round_words[i];
        end
        if (len_done_q) begin
          state_d = ST_OUT;
          oi_d    = 2'd0;
        end else if (eom_q) begin
          state_d = ST_PAD;
          if (!pad_on_q) begin
            // block filled by the last byte: fresh padding block
            pw_d     = cnt_q[5:2];
            first_d  = 1'b1;
            second_d = 1'b0;
            pad_on_d = 1'b1;
          end else begin
            // length did not fit: zero block carrying the length
            pw_d     = 4'd0;
            first_d  = 1'b0;
            second_d = 1'b1;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          dw_d        = chain_q[oi_q];
          wi_d        = oi_q;
          lw_d        = (oi_q == 2'd3);
          oi_d        = oi_q + 2'd1;
          if (oi_q == 2'd3) begin
            chain_d    = md5he_pkg::IV_WORDS;
            cnt_d      = '0;
            eom_d      = 1'b0;
            pad_on_d   = 1'b0;
            len_done_d = 1'b0;
            state_d    = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pw_q        <= '0;
      first_q     <= 1'b0;
      second_q    <= 1'b0;
      pad_on_q    <= 1'b0;
      eom_q       <= 1'b0;
      len_done_q  <= 1'b0;
      rnd_q       <= '0;
      oi_q        <= '0;
      chain_q     <= md5he_pkg::IV_WORDS;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pw_q        <= pw_d;
      first_q     <= first_d;
      second_q    <= second_d;
      pad_on_q    <= pad_on_d;
      eom_q       <= eom_d;
      len_done_q  <= len_done_d;
      rnd_q       <= rnd_d;
      oi_q        <= oi_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dw_q <= dw_d;
    wi_q <= wi_d;
    lw_q <= lw_d;
  end

  // block memory: byte-lane writes, registered read
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      if (mem_we[l]) begin
        blk_mem[mem_waddr][l*8 +: 8] <= mem_wdata[l*8 +: 8];
      end
    end
    mem_rdata_q <= blk_mem[mem_raddr];
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = dw_q;
  assign word_index_o  = wi_q;
  assign last_word_o   = lw_q;

endmodule

// ===== rtl/core/md5he_checker.sv =====
// md5he_checker: port-level checks for md5_hash_engine, attached by bind.
// No package dependencies; sees only the top level's ports.

module md5he_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] digest_word_o,
  input logic [1:0]  word_index_o,
  input logic        last_word_o
);

  // stalled digest word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digest_word_o)
      && $stable(word_index_o))
    else $error("digest word changed while stalled");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 2'd3)))
    else $error("last_word does not match word_index");

  // no new message can finish right after a digest completes
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_word_o |=> !out_valid_o)
    else $error("output valid right after final digest transfer");

  // input is held off while a digest is still being emitted
  a_no_input_mid_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_word_o |-> !in_ready_o)
    else $error("input ready in the middle of a digest");

endmodule

bind md5_hash_engine md5he_checker u_md5he_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .digest_word_o (digest_word_o),
  .word_index_o  (word_index_o),
  .last_word_o   (last_word_o)
);
